// ===== sv/fpa_pkg.sv =====
// package for the q24.8 fixed-point alu
// opcode codes, result width constants and the sideband record handed down the divider chain
// no dependencies
package fpa_pkg;

    localparam int DATA_W             = 32;
    localparam int FRACTION_BITS_DEF  = 8;
    localparam int OPCODE_W           = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD          = 4'd0,
        OP_SUB          = 4'd1,
        OP_MUL          = 4'd2,
        OP_DIV          = 4'd3,
        OP_MIN          = 4'd4,
        OP_MAX          = 4'd5,
        OP_INC          = 4'd6,
        OP_DEC          = 4'd7,
        OP_INT_TO_FIXED = 4'd8,
        OP_FIXED_TO_INT = 4'd9
    } op_t;

    // everything an item carries besides the divider's working values
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              div_zero;
        logic              negate;
        logic              a_less;
        logic              a_equal;
        logic              a_greater;
        logic [DATA_W-1:0] other_res;
    } side_t;

endpackage

// ===== sv/fpa_prep.sv =====
// input stage of the alu: decodes the opcode, runs the multiplier and the other non-divide ops,
// and loads the operand magnitudes for the divider chain
// depends on fpa_pkg
module fpa_prep
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int DW            = DATA_W + FRACTION_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [OPCODE_W-1:0]      in_opcode,
    input  logic signed [DATA_W-1:0] in_a,
    input  logic signed [DATA_W-1:0] in_b,
    output side_t                    side_reg,
    output logic [DW-1:0]            dvd_reg,
    output logic [DATA_W-1:0]        dsr_reg
);

    op_t                       op;
    logic signed [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]         abs_a;
    logic [DATA_W-1:0]         abs_b;
    logic                      lt;
    logic                      gt;
    side_t                     side_next;

    assign op    = op_t'(in_opcode);
    assign prod  = in_a * in_b;
    assign abs_a = in_a[DATA_W-1] ? (~in_a + 1'b1) : in_a;
    assign abs_b = in_b[DATA_W-1] ? (~in_b + 1'b1) : in_b;
    assign lt    = in_a < in_b;
    assign gt    = in_a > in_b;

    always_comb begin
        side_next           = '0;
        side_next.valid     = in_valid;
        side_next.is_div    = (op == OP_DIV);
        side_next.div_zero  = (op == OP_DIV) && (in_b == '0);
        side_next.negate    = in_a[DATA_W-1] ^ in_b[DATA_W-1];
        side_next.a_less    = lt;
        side_next.a_equal   = (in_a == in_b);
        side_next.a_greater = gt;
        unique case (op)
            OP_ADD:          side_next.other_res = in_a + in_b;
            OP_SUB:          side_next.other_res = in_a - in_b;
            OP_MUL:          side_next.other_res = prod[FRACTION_BITS +: DATA_W];
            OP_MIN:          side_next.other_res = lt ? in_a : in_b;
            OP_MAX:          side_next.other_res = gt ? in_a : in_b;
            OP_INC:          side_next.other_res = in_a + 1'b1;
            OP_DEC:          side_next.other_res = in_a - 1'b1;
            OP_INT_TO_FIXED: side_next.other_res = in_a << FRACTION_BITS;
            OP_FIXED_TO_INT: side_next.other_res = in_a >>> FRACTION_BITS;
            default:         side_next.other_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_next;
            dvd_reg  <= {abs_a, {FRACTION_BITS{1'b0}}};
            dsr_reg  <= abs_b;
        end
    end

endmodule

// ===== sv/fpa_div_cell.sv =====
// one restoring-division cell: settles one quotient bit and passes the item to the next cell
// depends on fpa_pkg
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int DW = DATA_W + FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  side_t             side_in,
    input  logic [DATA_W-1:0] rem_in,
    input  logic [DW-1:0]     dvd_in,
    input  logic [DATA_W-1:0] quo_in,
    input  logic [DATA_W-1:0] dsr_in,
    output side_t             side_reg,
    output logic [DATA_W-1:0] rem_reg,
    output logic [DW-1:0]     dvd_reg,
    output logic [DATA_W-1:0] quo_reg,
    output logic [DATA_W-1:0] dsr_reg
);

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic [DATA_W-1:0] rem_next;

    // bring down the next dividend bit and try to subtract the divisor
    assign trial    = {rem_in, dvd_in[DW-1]};
    assign diff     = trial - {1'b0, dsr_in};
    assign fits     = trial >= {1'b0, dsr_in};
    assign rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.valid <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_in[DW-2:0], 1'b0};
            quo_reg  <= {quo_in[DATA_W-2:0], fits};
            dsr_reg  <= dsr_in;
        end
    end

endmodule

// ===== sv/fpa_post.sv =====
// output stage: applies the quotient sign, picks the result and holds the outgoing transfer
// depends on fpa_pkg
module fpa_post
    import fpa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  side_t             side_in,
    input  logic [DATA_W-1:0] quo_in,
    output logic              out_valid_reg,
    output logic [DATA_W-1:0] out_res_reg,
    output logic [3:0]        out_flags_reg
);

    logic [DATA_W-1:0] res_next;

    always_comb begin
        priority if (!side_in.is_div) begin
            res_next = side_in.other_res;
        end else if (side_in.div_zero) begin
            res_next = '0;
        end else if (side_in.negate) begin
            res_next = ~quo_in + 1'b1;
        end else begin
            res_next = quo_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= side_in.valid;
            out_res_reg   <= res_next;
            out_flags_reg <= {side_in.div_zero, side_in.a_greater,
                              side_in.a_equal, side_in.a_less};
        end
    end

endmodule

// ===== sv/fixed_point_alu_q24_8_unit.sv =====
// signed 32-bit fixed-point alu, top level: input stage, divider cell chain, output stage
// throughput: one item per cycle if not stalled, via 32 + FRACTION_BITS one-bit divider cells
// the whole pipeline holds while a result waits on m_tready; bubbles pass through
// reset: synchronous, active low, clears every valid bit; no result is pending after reset
// depends on fpa_pkg, fpa_prep, fpa_div_cell, fpa_post
module fixed_point_alu_q24_8_unit
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,   // opcode [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value [31:0]
    output logic [3:0]  m_tuser    // a_less, a_equal, a_greater, divide_by_zero
);

    localparam int DW = DATA_W + FRACTION_BITS;

    logic              en;
    side_t             side_c [DW+1];
    logic [DATA_W-1:0] rem_c  [DW+1];
    logic [DW-1:0]     dvd_c  [DW+1];
    logic [DATA_W-1:0] quo_c  [DW+1];
    logic [DATA_W-1:0] dsr_c  [DW+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    fpa_prep #(
        .FRACTION_BITS (FRACTION_BITS),
        .DW            (DW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .side_reg  (side_c[0]),
        .dvd_reg   (dvd_c[0]),
        .dsr_reg   (dsr_c[0])
    );

    assign rem_c[0] = '0;
    assign quo_c[0] = '0;

    for (genvar i = 0; i < DW; i++) begin : g_cell
        fpa_div_cell #(
            .DW (DW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .side_in  (side_c[i]),
            .rem_in   (rem_c[i]),
            .dvd_in   (dvd_c[i]),
            .quo_in   (quo_c[i]),
            .dsr_in   (dsr_c[i]),
            .side_reg (side_c[i+1]),
            .rem_reg  (rem_c[i+1]),
            .dvd_reg  (dvd_c[i+1]),
            .quo_reg  (quo_c[i+1]),
            .dsr_reg  (dsr_c[i+1])
        );
    end

    fpa_post u_post (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .side_in       (side_c[DW]),
        .quo_in        (quo_c[DW]),
        .out_valid_reg (m_tvalid),
        .out_res_reg   (m_tdata),
        .out_flags_reg (m_tuser)
    );

    // exactly one comparison flag on every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tuser[2:0]))
        else $error("comparison flags not one-hot");

    // a zero divisor forces a zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tdata == '0))
        else $error("divide by zero with nonzero result");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for fixed_point_alu_q24_8_unit, the q24.8 fixed-point alu
// queue-fed stream driver, stalling result monitor and an in-bench prediction of every result
// depends on fpa_pkg and the alu rtl
`timescale 1ns / 100ps

module tb_top;
    import fpa_pkg::*;

    localparam int          FRAC          = FRACTION_BITS_DEF;
    localparam int          RANDOM_ITEMS  = 1500;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          LONG_HOLD     = 300;
    localparam int          HOLD_AT       = 400;
    localparam logic [3:0]  OP_UNUSED_LO  = 4'd10;
    localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
    localparam logic [31:0] Q_MAX         = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;
    localparam logic [31:0] Q_ONE         = 32'h0000_0100;

    typedef struct {
        logic [3:0]  opc;
        logic [31:0] a;
        logic [31:0] b;
        bit          drain_first;   // wait for all results before offering this one
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  flags;         // a_less, a_equal, a_greater, divide_by_zero from bit 0
    } alu_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // operand_a [31:0], operand_b [63:32]
    logic [3:0]  s_tuser  = '0;     // opcode [3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // result_value [31:0]
    logic [3:0]  m_tuser;           // a_less, a_equal, a_greater, divide_by_zero

    alu_op_t     op_q[$];
    alu_result_t result_q[$];
    alu_op_t     cur_op = '{4'd0, 32'd0, 32'd0, 1'b0};
    int          ops_sent     = 0;
    int          results_seen = 0;
    int          total_ops    = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    // sender burst state
    int          burst_left = 0;
    int          gap_left   = 0;
    bit          offer;

    // receiver stall state
    int          stall_mode = 0;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 0;
    bit          rdy;
    alu_result_t want;

    fixed_point_alu_q24_8_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic alu_result_t predict_alu(logic [3:0] opc, logic [31:0] a,
                                                logic [31:0] b);
        alu_result_t r;
        longint      sa;
        longint      sb;
        longint      wide;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        wide = 0;
        r.flags = {1'b0, sa > sb, sa == sb, sa < sb};
        case (opc)
            OP_ADD:          wide = sa + sb;
            OP_SUB:          wide = sa - sb;
            OP_MUL:          wide = (sa * sb) >>> FRAC;
            OP_DIV: begin
                if (sb == 0)
                    r.flags[3] = 1'b1;
                else
                    wide = (sa * (longint'(1) << FRAC)) / sb;   // truncates toward zero
            end
            OP_MIN:          wide = (sa < sb) ? sa : sb;
            OP_MAX:          wide = (sa > sb) ? sa : sb;
            OP_INC:          wide = sa + 1;
            OP_DEC:          wide = sa - 1;
            OP_INT_TO_FIXED: wide = sa << FRAC;
            OP_FIXED_TO_INT: wide = sa >>> FRAC;
            default:         wide = 0;
        endcase
        r.value = wide[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 2047) - 1024;
            7: begin
                case ($urandom_range(0, 6))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'hffff_ffff;
                    3: v = Q_MAX;
                    4: v = Q_MIN;
                    5: v = Q_ONE;
                    default: v = -Q_ONE;
                endcase
            end
            default:    v = ($urandom_range(0, 255) - 128) << FRAC;   // whole numbers
        endcase
        return v;
    endfunction

    task automatic queue_op(logic [3:0] opc, logic [31:0] a, logic [31:0] b, bit drain);
        op_q.push_back('{opc, a, b, drain});
        total_ops++;
    endtask

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [3:0] exp_f,
                                   logic [31:0] got_v, logic [3:0] got_f);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected value %h flags %b, got value %h flags %b",
                     $realtime, what, exp_v, exp_f, got_v, got_f);
    endtask

    // driver: holds a pending transfer, otherwise offers the next op in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(predict_alu(cur_op.opc, cur_op.a, cur_op.b));
                ops_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                offer = 0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_q.size() > 0 &&
                             !(op_q[0].drain_first && ops_sent != results_seen)) begin
                    cur_op = op_q.pop_front();
                    offer = 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                s_tvalid <= offer;
                s_tdata  <= {cur_op.b, cur_op.a};
                s_tuser  <= cur_op.opc;
            end
        end
    end

    // monitor: checks each result transfer and drives its own stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 'x, 'x, m_tdata, m_tuser);
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("result_value", want.value, want.flags,
                                        m_tdata, m_tuser);
                    else if (m_tuser !== want.flags)
                        report_mismatch("flags", want.value, want.flags, m_tdata, m_tuser);
                end
            end
            // one long hold-off lets the pipeline fill and push back on the sender
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(5, 60);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       rdy = 1;
                    1:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixed_point_alu_q24_8_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] ra;
        logic [31:0] rb;
        logic [3:0]  ropc;

        // directed: wrap edges, each operation, division by zero, unused opcodes
        queue_op(OP_ADD, Q_MAX, 32'd1, 0);
        queue_op(OP_ADD, Q_MIN, Q_MIN, 0);
        queue_op(OP_SUB, Q_MIN, 32'd1, 0);
        queue_op(OP_SUB, Q_MAX, 32'hffff_ffff, 0);
        queue_op(OP_MUL, Q_MAX, Q_MAX, 0);
        queue_op(OP_MUL, Q_MIN, Q_MIN, 0);
        queue_op(OP_MUL, -Q_ONE - 32'd128, Q_ONE + 32'd1, 0);
        queue_op(OP_MUL, 32'hffff_ffff, 32'd1, 0);
        queue_op(OP_DIV, 32'd3 << FRAC, 32'd2 << FRAC, 0);
        queue_op(OP_DIV, -(32'd7), 32'd2 << FRAC, 0);
        queue_op(OP_DIV, Q_MAX, 32'd0, 0);
        queue_op(OP_DIV, 32'd0, 32'd0, 0);
        queue_op(OP_DIV, Q_MIN, 32'hffff_ffff, 0);
        queue_op(OP_DIV, Q_MAX, 32'd1, 0);
        queue_op(OP_MIN, Q_MIN, Q_MAX, 0);
        queue_op(OP_MAX, Q_MIN, Q_MAX, 0);
        queue_op(OP_MIN, 32'd5, 32'd5, 0);
        queue_op(OP_INC, Q_MAX, Q_MIN, 0);
        queue_op(OP_DEC, Q_MIN, Q_MAX, 0);
        queue_op(OP_INT_TO_FIXED, Q_MAX, 32'd0, 0);
        queue_op(OP_INT_TO_FIXED, 32'hffff_fffe, 32'd0, 0);
        queue_op(OP_FIXED_TO_INT, Q_MIN + 32'd1, 32'd0, 0);
        queue_op(OP_FIXED_TO_INT, Q_MAX, Q_MAX, 0);
        queue_op(OP_UNUSED_LO, 32'd1, 32'd2, 0);
        queue_op(OP_UNUSED_HI, Q_MAX, Q_MAX, 1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 15) == 0)
                ropc = $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI);
            else
                ropc = $urandom_range(OP_ADD, OP_FIXED_TO_INT);
            ra = pick_operand();
            rb = ($urandom_range(0, 7) == 0) ? ra : pick_operand();
            if (ropc == OP_DIV && $urandom_range(0, 9) == 0)
                rb = 32'd0;
            queue_op(ropc, ra, rb, (i % 500) == 250);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_sent < total_ops)
            @(posedge aclk);
        while (result_q.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (result_q.size() != 0)
            report_mismatch("expected result never arrived", result_q[0].value,
                            result_q[0].flags, 'x, 'x);
        if (mismatches == 0)
            $display("fixed_point_alu_q24_8_unit regression: pass");
        else
            $display("fixed_point_alu_q24_8_unit regression: fail");
        $finish;
    end

endmodule
